[src/lpim_pkg.sv]
// Shared types, codes and defaults for the linear-probing id map.
`default_nettype none

package lpim_pkg;

  // Fixed field widths of the request and result transactions.
  localparam int REGION_ID_W = 32;
  localparam int REF_W       = 11;

  // Defaults for the top-level parameters.
  localparam int DEF_TABLE_ENTRIES = 1024;
  localparam int DEF_KEY_BITS      = 32;

  // Request mode: bit set means register the region and assign a new id.
  localparam logic MODE_REGISTER = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2
  } lpim_status_t;

  typedef struct packed {
    logic [REF_W-1:0] reference_id;
    lpim_status_t     status;
  } lpim_result_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_CHECK,
    ST_DONE
  } lpim_state_t;

endpackage

`default_nettype wire

[src/linear_probe_id_map.sv]
// Top level of the linear-probing region id to reference id map.
`default_nettype none

// Each request transaction either looks up the reference id of a region id or
// registers the region under a freshly counted id (the first is 1); exactly one
// result transaction follows each request. The table lives in one synchronous
// memory of TABLE_ENTRIES words holding a used flag, the key and the id. After
// reset a clearing pass writes every word once, and no request is taken until
// it has finished. Requests are served one at a time. Each request finds its
// home slot and then probes slot by slot; the probe loop reads one slot per
// cycle from the memory's single read port. With a power-of-two table the
// home slot is the low key bits; with any other table size it comes from a
// reciprocal multiplication with a final correction.
// The result sits in an output register, so a new request is taken while the
// previous result still waits for out_ready.

module linear_probe_id_map
  import lpim_pkg::*;
#(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  parameter int KEY_BITS      = DEF_KEY_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output      logic                   in_ready,
  input  wire logic                   in_mode,
  input  wire logic [REGION_ID_W-1:0] in_region_id,
  output      logic                   out_valid,
  input  wire logic                   out_ready,
  output      logic [REF_W-1:0]       out_reference_id,
  output      logic [1:0]             out_status
);

  localparam int SLOT_W = $clog2(TABLE_ENTRIES);
  // Memory word: used flag, key, reference id.
  localparam int DATA_W = 1 + KEY_BITS + REF_W;

  logic              res_valid;
  logic              res_ready;
  lpim_result_t      res;
  logic              mem_rd_en;
  logic [SLOT_W-1:0] mem_rd_addr;
  logic [DATA_W-1:0] mem_rd_data;
  logic              mem_wr_en;
  logic [SLOT_W-1:0] mem_wr_addr;
  logic [DATA_W-1:0] mem_wr_data;

  logic              out_valid_r;
  lpim_result_t      out_res_r;

  lpim_probe #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .KEY_BITS      (KEY_BITS),
    .SLOT_W        (SLOT_W),
    .DATA_W        (DATA_W)
  ) u_probe (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_mode      (in_mode),
    .in_region_id (in_region_id),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .mem_rd_en    (mem_rd_en),
    .mem_rd_addr  (mem_rd_addr),
    .mem_rd_data  (mem_rd_data),
    .mem_wr_en    (mem_wr_en),
    .mem_wr_addr  (mem_wr_addr),
    .mem_wr_data  (mem_wr_data)
  );

  lpim_ram #(
    .DEPTH  (TABLE_ENTRIES),
    .ADDR_W (SLOT_W),
    .DATA_W (DATA_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // The output register takes a new result whenever it is empty or is being
  // emptied in the same cycle; while it stays full the sequencer waits in ST_DONE.
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_reference_id = out_res_r.reference_id;
  assign out_status       = out_res_r.status;

endmodule

`default_nettype wire

[src/lpim_ram.sv]
// Single-port-write, single-port-read table memory with a registered read.
`default_nettype none

module lpim_ram #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10,
  parameter int DATA_W = 44
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output      logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[src/lpim_home.sv]
// Home slot unit: the key modulo the table size, by masking or by reciprocal multiplication.
`default_nettype none

module lpim_home
  import lpim_pkg::*;
#(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  parameter int KEY_BITS      = DEF_KEY_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic [KEY_BITS-1:0]              key,
  output      logic                             done,
  output      logic [$clog2(TABLE_ENTRIES)-1:0] home
);

  localparam int SLOT_W  = $clog2(TABLE_ENTRIES);
  localparam int KEY_EFF = (KEY_BITS < REGION_ID_W) ? KEY_BITS : REGION_ID_W;
  localparam bit IS_POW2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;

  if (IS_POW2) begin : g_mask
    // A power-of-two table takes the low key bits directly.
    logic [SLOT_W+KEY_EFF-1:0] key_ext;
    logic [SLOT_W-1:0]         home_r;
    logic                      done_r;

    assign key_ext = {{SLOT_W{1'b0}}, key[KEY_EFF-1:0]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        done_r <= 1'b0;
      end else begin
        done_r <= start;
      end
    end

    always_ff @(posedge clk) begin
      if (start) begin
        home_r <= key_ext[SLOT_W-1:0];
      end
    end

    assign done = done_r;
    assign home = home_r;
  end else begin : g_recip
    // The estimated quotient floor(key * RECIP / 2^32) is the true quotient or one
    // less, so the estimated remainder lies below twice the table size and one
    // compare and subtract finishes it. Only the low SLOT_W+1 bits are carried.
    localparam longint unsigned RECIP_L   = (64'd1 << 32) / 64'(TABLE_ENTRIES);
    localparam logic [31:0]     RECIP     = 32'(RECIP_L);
    localparam logic [SLOT_W:0] ENTRIES_T = (SLOT_W + 1)'(TABLE_ENTRIES);

    logic [31:0]         key_w;
    logic [63:0]         prod;
    logic [SLOT_W:0]     q_lo_r;
    logic [SLOT_W:0]     x_lo_r;
    logic                v1_r;
    logic [2*SLOT_W+1:0] qn;
    logic [SLOT_W:0]     rest_r;
    logic [SLOT_W:0]     rest_sub;
    logic                done_r;

    assign key_w    = 32'(key[KEY_EFF-1:0]);
    assign prod     = {32'd0, key_w} * {32'd0, RECIP};
    assign qn       = {{(SLOT_W+1){1'b0}}, q_lo_r} * {{(SLOT_W+1){1'b0}}, ENTRIES_T};
    assign rest_sub = rest_r - ENTRIES_T;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v1_r   <= 1'b0;
        done_r <= 1'b0;
      end else begin
        v1_r   <= start;
        done_r <= v1_r;
      end
    end

    always_ff @(posedge clk) begin
      if (start) begin
        q_lo_r <= prod[32 +: SLOT_W+1];
        x_lo_r <= key_w[SLOT_W:0];
      end
      if (v1_r) begin
        rest_r <= x_lo_r - qn[SLOT_W:0];
      end
    end

    assign done = done_r;
    assign home = (rest_r >= ENTRIES_T) ? rest_sub[SLOT_W-1:0] : rest_r[SLOT_W-1:0];
  end

endmodule

`default_nettype wire

[src/lpim_probe.sv]
// Probe sequencer: clearing pass, home slot, slot-by-slot probe and table update.
`default_nettype none

module lpim_probe
  import lpim_pkg::*;
#(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  parameter int KEY_BITS      = DEF_KEY_BITS,
  parameter int SLOT_W        = $clog2(TABLE_ENTRIES),
  parameter int DATA_W        = 1 + KEY_BITS + REF_W
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output      logic                   in_ready,
  input  wire logic                   in_mode,
  input  wire logic [REGION_ID_W-1:0] in_region_id,
  output      logic                   res_valid,
  input  wire logic                   res_ready,
  output      lpim_result_t           res,
  output      logic                   mem_rd_en,
  output      logic [SLOT_W-1:0]      mem_rd_addr,
  input  wire logic [DATA_W-1:0]      mem_rd_data,
  output      logic                   mem_wr_en,
  output      logic [SLOT_W-1:0]      mem_wr_addr,
  output      logic [DATA_W-1:0]      mem_wr_data
);

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_ENTRIES - 1);
  localparam logic [SLOT_W:0]   ENTRIES_T = (SLOT_W + 1)'(TABLE_ENTRIES);

  lpim_state_t               state_r, state_nxt;
  logic [SLOT_W-1:0]         clr_addr_r, clr_addr_nxt;
  logic                      mode_r, mode_nxt;
  logic [KEY_BITS-1:0]       key_r, key_nxt;
  logic [SLOT_W-1:0]         slot_r, slot_nxt;
  logic [SLOT_W:0]           cnt_r, cnt_nxt;
  logic [REF_W-1:0]          last_ref_r, last_ref_nxt;
  lpim_result_t              res_r, res_nxt;

  logic [REGION_ID_W+KEY_BITS-1:0] id_ext;
  logic [KEY_BITS-1:0]       in_key;
  logic                      hash_start;
  logic                      home_done;
  logic [SLOT_W-1:0]         home_slot;
  logic [REF_W-1:0]          ref_inc;
  logic [SLOT_W-1:0]         slot_step;
  logic [SLOT_W:0]           cnt_step;
  logic                      rd_used;
  logic [KEY_BITS-1:0]       rd_key;
  logic [REF_W-1:0]          rd_ref;

  assign id_ext    = {{KEY_BITS{1'b0}}, in_region_id};
  assign in_key    = id_ext[KEY_BITS-1:0];
  assign ref_inc   = last_ref_r + REF_W'(1);
  assign slot_step = (slot_r == LAST_SLOT) ? '0 : slot_r + SLOT_W'(1);
  assign cnt_step  = cnt_r + (SLOT_W + 1)'(1);
  assign rd_used   = mem_rd_data[DATA_W-1];
  assign rd_key    = mem_rd_data[REF_W +: KEY_BITS];
  assign rd_ref    = mem_rd_data[REF_W-1:0];

  lpim_home #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .KEY_BITS      (KEY_BITS)
  ) u_home (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_start),
    .key   (in_key),
    .done  (home_done),
    .home  (home_slot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      cnt_r      <= '0;
      last_ref_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      cnt_r      <= cnt_nxt;
      last_ref_r <= last_ref_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;
    key_r  <= key_nxt;
    slot_r <= slot_nxt;
    res_r  <= res_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    mode_nxt     = mode_r;
    key_nxt      = key_r;
    slot_nxt     = slot_r;
    cnt_nxt      = cnt_r;
    last_ref_nxt = last_ref_r;
    res_nxt      = res_r;
    in_ready     = 1'b0;
    res_valid    = 1'b0;
    hash_start   = 1'b0;
    mem_rd_en    = 1'b0;
    mem_rd_addr  = slot_r;
    mem_wr_en    = 1'b0;
    mem_wr_addr  = slot_r;
    mem_wr_data  = {1'b1, key_r, ref_inc};

    unique case (state_r)
      ST_CLEAR: begin
        mem_wr_en    = 1'b1;
        mem_wr_addr  = clr_addr_r;
        mem_wr_data  = '0;
        clr_addr_nxt = clr_addr_r + SLOT_W'(1);
        if (clr_addr_r == LAST_SLOT) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          mode_nxt   = in_mode;
          key_nxt    = in_key;
          hash_start = 1'b1;
          state_nxt  = ST_HASH;
        end
      end
      ST_HASH: begin
        if (home_done) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = home_slot;
          slot_nxt    = home_slot;
          cnt_nxt     = '0;
          state_nxt   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!rd_used) begin
          if (mode_r == MODE_REGISTER) begin
            mem_wr_en    = 1'b1;
            last_ref_nxt = ref_inc;
            res_nxt      = '{reference_id: ref_inc, status: STATUS_OK};
          end else begin
            res_nxt = '{reference_id: {REF_W{1'b0}}, status: STATUS_NOT_FOUND};
          end
          state_nxt = ST_DONE;
        end else if ((mode_r != MODE_REGISTER) && (rd_key == key_r)) begin
          res_nxt   = '{reference_id: rd_ref, status: STATUS_OK};
          state_nxt = ST_DONE;
        end else if (cnt_step == ENTRIES_T) begin
          res_nxt   = '{reference_id: {REF_W{1'b0}},
                        status: (mode_r == MODE_REGISTER) ? STATUS_FULL : STATUS_NOT_FOUND};
          state_nxt = ST_DONE;
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = slot_step;
          slot_nxt    = slot_step;
          cnt_nxt     = cnt_step;
        end
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  assign res = res_r;

`ifndef NO_ASSERTIONS
  // A slot is only ever claimed when the probe found it free.
  a_claim_free: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_wr_en && (state_r == ST_CHECK)) |-> !rd_used)
    else $error("probe wrote over a used slot");

  // The probe never runs past one full turn of the table.
  a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < ENTRIES_T)
    else $error("probe count exceeded the table size");

  // The id counter moves only when a registration claims a slot.
  a_ref_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !((state_r == ST_CHECK) && (mode_r == MODE_REGISTER) && !rd_used)
    |=> $stable(last_ref_r))
    else $error("reference counter changed without a registration");

  // The home slot unit only finishes while the sequencer waits for it.
  a_home_timing: assert property (@(posedge clk) disable iff (!rst_n)
    home_done |-> (state_r == ST_HASH))
    else $error("home slot ready outside the hash wait");
`endif

endmodule

`default_nettype wire
